[rtl/core/ordered_list_append_delete_core_macros.svh]
// Assertion macros shared by the ordered list core.
`ifndef ORDERED_LIST_APPEND_DELETE_CORE_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define OLAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list core: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list core: next-cycle check failed");

// Check that the consequent holds after the antecedent.
`define OLAD_ASSERT_LATER(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("ordered list core: two-cycle check failed");

`endif

[rtl/core/olad_pkg.sv]
// Shared constants and types of the ordered list core.
package olad_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int DATA_W     = 32;

    // Operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Commands broadcast to every cell
    typedef struct packed {
        logic append_en;
        logic delete_en;
        logic rotate_en;
    } cell_ctrl_t;

    // Where a cell sits relative to the current fill level
    typedef struct packed {
        logic occupied;
        logic is_tail;
        logic is_end;
    } cell_pos_t;

endpackage

[rtl/core/ordered_list_append_delete_core.sv]
// Top level of the ordered list core: command port, sequencer and chain of cells.
//
// Bounded ordered list of signed 32-bit entries kept in a row of cells, one entry per cell.
// An operation is taken when start is high and busy is low. Append and delete are accepted,
// then every cell compares and shifts at once, and each gives one result. In a dump the
// cells rotate the list toward the head one place per cycle and the head cell is sent out,
// so after n steps, for n entries, the list is back in its original order. Results are
// registered, each shown in the cycle after the work that makes it, on the result ports
// for exactly one cycle with done high; the receiver cannot stall, so every result must
// be taken when shown. A new operation can be accepted in the cycle in which the final
// result of the previous one is shown. Opcode 3 is accepted and dropped.
`include "ordered_list_append_delete_core_macros.svh"

module ordered_list_append_delete_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [1:0]                   opcode,
    input  logic signed [olad_pkg::DATA_W-1:0]  value,
    output logic                                done,
    output logic        [1:0]                   status,
    output logic signed [olad_pkg::DATA_W-1:0]  entry_value,
    output logic                                last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    logic [olad_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [olad_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [1:0]                         op_reg, op_next;
    logic signed [olad_pkg::DATA_W-1:0] key_reg, key_next;
    logic                               done_reg, done_next;
    logic [1:0]                         status_reg, status_next;
    logic signed [olad_pkg::DATA_W-1:0] entry_reg, entry_next;
    logic                               last_reg, last_next;

    olad_pkg::cell_ctrl_t               ctrl;
    olad_pkg::cell_pos_t                pos [olad_pkg::LIST_DEPTH];
    logic signed [olad_pkg::DATA_W-1:0] cell_data [olad_pkg::LIST_DEPTH];
    logic signed [olad_pkg::DATA_W-1:0] right_data [olad_pkg::LIST_DEPTH];
    logic [olad_pkg::LIST_DEPTH:0]      found_chain;
    logic                               accept;

    assign accept         = start && (state_reg == S_IDLE);
    assign found_chain[0] = 1'b0;

    // Build the chain of cells
    genvar g;
    generate
        for (g = 0; g < olad_pkg::LIST_DEPTH; g++)
        begin : g_cell
            assign pos[g].occupied = (count_reg > olad_pkg::CNT_W'(g));
            assign pos[g].is_tail  = (count_reg == olad_pkg::CNT_W'(g));
            assign pos[g].is_end   = (count_reg == olad_pkg::CNT_W'(g + 1));

            if (g == olad_pkg::LIST_DEPTH - 1)
            begin : g_edge
                assign right_data[g] = '0;
            end
            else
            begin : g_inner
                assign right_data[g] = cell_data[g + 1];
            end

            olad_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (pos[g]),
                .key        (key_reg),
                .right_data (right_data[g]),
                .head_data  (cell_data[0]),
                .found_in   (found_chain[g]),
                .found_out  (found_chain[g + 1]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    // Sequence the operation and form the result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = olad_pkg::ST_OK;
        entry_next  = '0;
        last_next   = 1'b0;
        ctrl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = opcode;
                    key_next = value;
                    idx_next = '0;
                    if (opcode != olad_pkg::OP_NONE)
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                done_next  = 1'b1;
                last_next  = 1'b1;
                state_next = S_IDLE;
                case (op_reg)
                    olad_pkg::OP_APPEND:
                    begin
                        if (count_reg == olad_pkg::CNT_W'(olad_pkg::LIST_DEPTH))
                        begin
                            status_next = olad_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.append_en = 1'b1;
                            count_next     = count_reg + olad_pkg::CNT_W'(1);
                        end
                    end
                    olad_pkg::OP_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = olad_pkg::ST_EMPTY;
                        end
                        else if (found_chain[olad_pkg::LIST_DEPTH])
                        begin
                            ctrl.delete_en = 1'b1;
                            count_next     = count_reg - olad_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            status_next = olad_pkg::ST_NOT_FOUND;
                        end
                    end
                    olad_pkg::OP_DUMP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = olad_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.rotate_en = 1'b1;
                            entry_next     = cell_data[0];
                            idx_next       = idx_reg + olad_pkg::IDX_W'(1);
                            last_next      = (olad_pkg::CNT_W'(idx_reg)
                                              == count_reg - olad_pkg::CNT_W'(1));
                            if (!last_next)
                            begin
                                state_next = S_RUN;
                            end
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                        last_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold payload of the transaction and the result
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_value = entry_reg;
    assign last        = last_reg;

    // Checks
    `OLAD_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= olad_pkg::CNT_W'(olad_pkg::LIST_DEPTH))
    `OLAD_ASSERT_SAME(a_done_after_run, clk, rst_n, done, $past(busy))
    `OLAD_ASSERT_NEXT(a_dump_continues, clk, rst_n, done && !last,
        done && (status == olad_pkg::ST_OK))
    `OLAD_ASSERT_LATER(a_append_grows, clk, rst_n,
        accept && (opcode == olad_pkg::OP_APPEND)
            && (count_reg != olad_pkg::CNT_W'(olad_pkg::LIST_DEPTH)),
        count_reg == $past(count_reg, 2) + olad_pkg::CNT_W'(1))

endmodule

[rtl/core/olad_cell.sv]
// One list slot: holds an entry, matches the key, shifts or rotates from its neighbor.
module olad_cell
(
    input  logic                                clk,
    input  olad_pkg::cell_ctrl_t                ctrl,
    input  olad_pkg::cell_pos_t                 pos,
    input  logic signed [olad_pkg::DATA_W-1:0]  key,
    input  logic signed [olad_pkg::DATA_W-1:0]  right_data,
    input  logic signed [olad_pkg::DATA_W-1:0]  head_data,
    input  logic                                found_in,
    output logic                                found_out,
    output logic signed [olad_pkg::DATA_W-1:0]  data
);

    logic signed [olad_pkg::DATA_W-1:0] data_reg;
    logic signed [olad_pkg::DATA_W-1:0] data_next;
    logic                               match;

    // Flag a match here or anywhere toward the head
    always_comb
    begin
        match     = pos.occupied && (data_reg == key);
        found_out = found_in | match;
    end

    // Pick the next entry: load at tail, close gap, or rotate toward head
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.append_en && pos.is_tail)
        begin
            data_next = key;
        end
        else if (ctrl.delete_en && found_out)
        begin
            data_next = right_data;
        end
        else if (ctrl.rotate_en && pos.occupied)
        begin
            data_next = pos.is_end ? head_data : right_data;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[tb/olad_checker.sv]
// Checker for the ordered list core: predicts every result and compares it with the block.
module olad_checker
    import olad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic        [1:0]          opcode,
    input  logic signed [DATA_W-1:0]   value,
    input  logic                       done,
    input  logic        [1:0]          status,
    input  logic signed [DATA_W-1:0]   entry_value,
    input  logic                       last,
    output int                         errors,
    output int                         pending,
    output int                         ops_seen,
    output int                         results_seen,
    output int                         full_seen,
    output int                         peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        [1:0]        status;
        logic signed [DATA_W-1:0] entry_value;
        logic                     last;
    } list_result_t;

    // Shadow copy of the list, head at index 0
    logic signed [DATA_W-1:0] shadow_list[$];
    list_result_t             expected_q[$];
    list_result_t             want;

    // Apply one command to the shadow list and queue the results it must give
    function automatic void predict_command(input logic [1:0] op,
                                            input logic signed [DATA_W-1:0] val);
        int pos;
        pos = -1;
        case (op)
            OP_APPEND:
            begin
                if (shadow_list.size() >= LIST_DEPTH)
                begin
                    expected_q.push_back('{ST_FULL, '0, 1'b1});
                    full_seen++;
                end
                else
                begin
                    shadow_list.push_back(val);
                    expected_q.push_back('{ST_OK, '0, 1'b1});
                end
            end
            OP_DELETE:
            begin
                if (shadow_list.size() == 0)
                    expected_q.push_back('{ST_EMPTY, '0, 1'b1});
                else
                begin
                    // find the first match from the head
                    foreach (shadow_list[i])
                        if (pos < 0 && shadow_list[i] == val)
                            pos = i;
                    if (pos < 0)
                        expected_q.push_back('{ST_NOT_FOUND, '0, 1'b1});
                    else
                    begin
                        shadow_list.delete(pos);
                        expected_q.push_back('{ST_OK, '0, 1'b1});
                    end
                end
            end
            OP_DUMP:
            begin
                if (shadow_list.size() == 0)
                    expected_q.push_back('{ST_EMPTY, '0, 1'b1});
                else
                    foreach (shadow_list[i])
                        expected_q.push_back('{ST_OK, shadow_list[i],
                                               i == shadow_list.size() - 1});
            end
            default:
            begin
                // unused opcode: drop without a result
            end
        endcase
        if (shadow_list.size() > peak_fill)
            peak_fill = shadow_list.size();
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shadow_list.delete();
            expected_q.delete();
            errors       = 0;
            pending      = 0;
            ops_seen     = 0;
            results_seen = 0;
            full_seen    = 0;
            peak_fill    = 0;
        end
        else
        begin
            // compare the result shown this cycle with the oldest expectation
            if (done)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: status %0d entry_value %0d last %0d",
                           status, entry_value, last);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (entry_value !== want.entry_value)
                    begin
                        $error("entry_value: expected %0d, got %0d",
                               want.entry_value, entry_value);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
            // predict the transaction taken this cycle
            if (start && !busy)
            begin
                ops_seen++;
                predict_command(opcode, value);
            end
            pending = expected_q.size();
        end
    end

endmodule

[tb/tb.sv]
// Testbench top for the ordered list core: clock, reset, command stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olad_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 104;
    localparam int MODE_ITEMS   = 32;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                     clk    = 1'b0;
    logic                     rst_n  = 1'b0;
    logic                     start  = 1'b0;
    logic        [1:0]        opcode = OP_NONE;
    logic signed [DATA_W-1:0] value  = '0;
    logic                     busy;
    logic                     done;
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last;
    logic                     took;

    int errors;
    int pending;
    int ops_seen;
    int results_seen;
    int full_seen;
    int peak_fill;
    int stall_cnt = 0;
    int idle_pct  = 0;

    // sender idle percentage per phase; the third phase would stall the receiver,
    // which cannot hold results off, so it runs flat out
    int phase_idle[4] = '{0, 86, 0, 31};

    // values appended lately, used as delete keys likely to hit
    logic signed [DATA_W-1:0] recent_q[$];

    always #HALF_PERIOD clk = ~clk;

    ordered_list_append_delete_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .value       (value),
        .done        (done),
        .status      (status),
        .entry_value (entry_value),
        .last        (last)
    );

    olad_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .value        (value),
        .done         (done),
        .status       (status),
        .entry_value  (entry_value),
        .last         (last),
        .errors       (errors),
        .pending      (pending),
        .ops_seen     (ops_seen),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .peak_fill    (peak_fill)
    );

    // Register the handshake so the driver can read it at the falling edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            took <= 1'b0;
        else
            took <= start && !busy;
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    // Drive one command and hold it until the block takes it
    task automatic send_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        opcode <= op;
        value  <= val;
        do
            @(negedge clk);
        while (!took);
    endtask

    // Drop start and hold off until every expected result has come
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Mix extremes, a narrow band that makes duplicates, and full-range values
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] extremes[4] = '{VAL_MIN, VAL_MAX, '0, -1};
        int                       roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return extremes[$urandom_range(3)];
        else if (roll < 45)
            return $urandom_range(8) - 4;
        else
            return $urandom;
    endfunction

    // Pick one command, leaning toward appends while filling and deletes while draining
    task automatic send_random(input bit filling);
        int                       op_roll;
        logic [1:0]               op;
        logic signed [DATA_W-1:0] val;
        op_roll = $urandom_range(99);
        if (filling)
            op = (op_roll < 70) ? OP_APPEND : (op_roll < 85) ? OP_DELETE :
                 (op_roll < 97) ? OP_DUMP : OP_NONE;
        else
            op = (op_roll < 15) ? OP_APPEND : (op_roll < 80) ? OP_DELETE :
                 (op_roll < 97) ? OP_DUMP : OP_NONE;
        case (op)
            OP_APPEND:
            begin
                val = pick_value();
                recent_q.push_back(val);
                if (recent_q.size() > LIST_DEPTH)
                    void'(recent_q.pop_front());
            end
            OP_DELETE:
            begin
                if ($urandom_range(99) < 60 && recent_q.size() > 0)
                    val = recent_q[$urandom_range(recent_q.size() - 1)];
                else
                    val = pick_value();
            end
            default:
                val = $urandom;
        endcase
        send_cmd(op, val);
    endtask

    initial
    begin
        int n;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, extremes, duplicates, misses, deletes at head, middle and tail
        send_cmd(OP_DUMP, VAL_MAX);
        send_cmd(OP_DELETE, '0);
        send_cmd(OP_NONE, VAL_MIN);
        send_cmd(OP_APPEND, VAL_MIN);
        send_cmd(OP_APPEND, VAL_MAX);
        send_cmd(OP_APPEND, '0);
        send_cmd(OP_APPEND, -1);
        send_cmd(OP_APPEND, 32'sh5555_5555);
        send_cmd(OP_APPEND, 32'shAAAA_AAAA);
        send_cmd(OP_APPEND, VAL_MIN);
        send_cmd(OP_DUMP, '0);
        send_cmd(OP_DELETE, 32'sd77);
        send_cmd(OP_DELETE, VAL_MIN);
        send_cmd(OP_DELETE, -1);
        send_cmd(OP_DELETE, VAL_MIN);
        send_cmd(OP_DUMP, -1);
        send_cmd(OP_NONE, VAL_MAX);
        send_cmd(OP_DELETE, 32'shAAAA_AAAA);
        send_cmd(OP_DUMP, VAL_MIN);

        // random phases, each started from a drained block
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            idle_pct = phase_idle[phase];
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random(((n / MODE_ITEMS) % 2) == 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        $display("Run covered %0d commands and %0d results over four pacing phases.",
                 ops_seen, results_seen);
        $display("List peaked at %0d of %0d entries; %0d appends refused as full.",
                 peak_fill, LIST_DEPTH, full_seen);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
